// ===== hw/rtl/rvfp_pkg.sv =====
// Package for the radar vital frame parser.
// Holds the frame layout constants, type codes, result codes and the type decoders.
// No dependencies.
package rvfp_pkg;

    // Frame layout
    localparam int HEADER_BYTES         = 8;
    localparam int FULL_PAYLOAD_BYTES   = 12;
    localparam int DIST_PAYLOAD_BYTES   = 8;
    localparam int SINGLE_PAYLOAD_BYTES = 4;
    localparam int HDR_SUM_BYTES        = 7;   // header bytes covered by the header checksum
    localparam int TYPE_HI_POS          = 5;
    localparam int TYPE_LO_POS          = 6;

    // Position counter covers header, longest payload and the checksum byte
    localparam int POS_W = $clog2(HEADER_BYTES + FULL_PAYLOAD_BYTES + 1);

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int TYPE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 3;

    // Frame type codes
    localparam logic [TYPE_W-1:0] TYPE_ALL      = 16'h0A13;
    localparam logic [TYPE_W-1:0] TYPE_BREATH   = 16'h0A14;
    localparam logic [TYPE_W-1:0] TYPE_HEART    = 16'h0A15;
    localparam logic [TYPE_W-1:0] TYPE_DISTANCE = 16'h0A16;

    // Reset value of the start byte register
    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h01;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_HDR_ERR  = 2'd1,
        ST_DATA_ERR = 2'd2
    } t_status;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALL      = 3'd0,
        KIND_BREATH   = 3'd1,
        KIND_HEART    = 3'd2,
        KIND_DISTANCE = 3'd3,
        KIND_UNKNOWN  = 3'd4
    } t_kind;

    function automatic t_kind kind_of(input logic [TYPE_W-1:0] code);
        t_kind k;
        unique case (code)
            TYPE_ALL:      k = KIND_ALL;
            TYPE_BREATH:   k = KIND_BREATH;
            TYPE_HEART:    k = KIND_HEART;
            TYPE_DISTANCE: k = KIND_DISTANCE;
            default:       k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [POS_W-1:0] payload_len(input t_kind k);
        logic [POS_W-1:0] len;
        unique case (k)
            KIND_ALL:      len = POS_W'(FULL_PAYLOAD_BYTES);
            KIND_DISTANCE: len = POS_W'(DIST_PAYLOAD_BYTES);
            default:       len = POS_W'(SINGLE_PAYLOAD_BYTES);
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/radar_vital_frame_parser.sv =====
// The result is registered: it appears on the output register in the cycle after the frame's last beat.
// Throughput: one byte beat per cycle; the input stalls only while a finished result
// is held and not taken at the output.
// The byte position counter and running XOR checksums set the per-byte path.
// Reset (synchronous, active low) clears the frame state, measurement stores and
// output valid, and sets the start byte register to 1.
// Top level of the radar vital frame parser; depends on rvfp_pkg.
module radar_vital_frame_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [rvfp_pkg::BYTE_W-1:0]     i_cfg_wdata,
    // byte input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [rvfp_pkg::BYTE_W-1:0]     i_byte_value,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rvfp_pkg::STATUS_W-1:0]   o_frame_status,
    output logic [rvfp_pkg::KIND_W-1:0]     o_frame_kind,
    output logic [rvfp_pkg::TYPE_W-1:0]     o_raw_type_code,
    output logic [rvfp_pkg::WORD_W-1:0]     o_breath_value_bits,
    output logic [rvfp_pkg::WORD_W-1:0]     o_heart_value_bits,
    output logic [rvfp_pkg::WORD_W-1:0]     o_distance_value_bits,
    output logic                            o_target_present
);
    import rvfp_pkg::*;

    // Config and frame state
    logic [BYTE_W-1:0]  r_start_byte;
    logic [POS_W-1:0]   r_pos,        n_pos;
    logic [BYTE_W-1:0]  r_hdr_xor,    n_hdr_xor;
    logic [BYTE_W-1:0]  r_pay_xor,    n_pay_xor;
    logic               r_start_ok,   n_start_ok;
    logic [TYPE_W-1:0]  r_type,       n_type;
    logic [BYTE_W-1:0]  r_hdr_chk,    n_hdr_chk;

    // Measurement stores
    logic [WORD_W-1:0]  r_breath,     n_breath;
    logic [WORD_W-1:0]  r_heart,      n_heart;
    logic [WORD_W-1:0]  r_distance,   n_distance;
    logic               r_present,    n_present;

    // Payload words 0 and 1; word 2 of a full frame is never used
    logic [WORD_W-1:0]  r_words [2];
    logic               word_we;
    logic               word_sel;
    logic [1:0]         word_lane;

    // Output register
    logic               r_out_valid,  n_out_valid;
    t_status            r_out_status;
    t_kind              r_out_kind;
    logic [TYPE_W-1:0]  r_out_type;

    logic               in_beat;
    logic               res_fire;
    t_status            res_status;
    t_kind              cur_kind;
    logic [POS_W-1:0]   cur_plen;
    logic [POS_W-1:0]   pay_idx;
    logic               hdr_ok;
    logic               data_ok;

    // Accept a byte whenever the result slot is free or draining
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign in_beat    = i_in_valid & o_in_ready;

    assign cur_kind = kind_of(r_type);
    assign cur_plen = payload_len(cur_kind);
    assign pay_idx  = r_pos - POS_W'(HEADER_BYTES);
    assign hdr_ok   = (~r_hdr_xor == r_hdr_chk);
    assign data_ok  = (~r_pay_xor == i_byte_value);

    // Frame counting, checksums and store updates
    always_comb begin
        n_pos      = r_pos;
        n_hdr_xor  = r_hdr_xor;
        n_pay_xor  = r_pay_xor;
        n_start_ok = r_start_ok;
        n_type     = r_type;
        n_hdr_chk  = r_hdr_chk;
        n_breath   = r_breath;
        n_heart    = r_heart;
        n_distance = r_distance;
        n_present  = r_present;
        word_we    = 1'b0;
        word_sel   = pay_idx[2];
        word_lane  = pay_idx[1:0];
        res_fire   = 1'b0;
        res_status = ST_OK;

        if (in_beat) begin
            if (r_pos < POS_W'(HEADER_BYTES)) begin
                // header byte
                if (r_pos == '0) begin
                    n_start_ok = (i_byte_value == r_start_byte);
                end
                if (r_pos < POS_W'(HDR_SUM_BYTES)) begin
                    n_hdr_xor = r_hdr_xor ^ i_byte_value;
                end else begin
                    n_hdr_chk = i_byte_value;
                end
                if (r_pos == POS_W'(TYPE_HI_POS)) begin
                    n_type[15:8] = i_byte_value;
                end
                if (r_pos == POS_W'(TYPE_LO_POS)) begin
                    n_type[7:0] = i_byte_value;
                end
                n_pos = r_pos + 1'b1;
            end else if (pay_idx < cur_plen) begin
                // payload byte, little-endian into the word buffer
                n_pay_xor = r_pay_xor ^ i_byte_value;
                word_we   = (pay_idx[POS_W-1:3] == '0);
                n_pos     = r_pos + 1'b1;
            end else begin
                // data checksum byte closes the frame
                n_pos     = '0;
                n_hdr_xor = '0;
                n_pay_xor = '0;
                if (r_start_ok) begin
                    res_fire = 1'b1;
                    if (!hdr_ok) begin
                        res_status = ST_HDR_ERR;
                    end else if (cur_kind != KIND_UNKNOWN) begin
                        if (!data_ok) begin
                            res_status = ST_DATA_ERR;
                        end else begin
                            unique case (cur_kind)
                                KIND_ALL: begin
                                    n_breath = r_words[0];
                                    n_heart  = r_words[1];
                                end
                                KIND_BREATH:   n_breath = r_words[0];
                                KIND_HEART:    n_heart  = r_words[0];
                                KIND_DISTANCE: begin
                                    n_present  = (r_words[0] == 32'd1);
                                    n_distance = r_words[1];
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
        end

        n_out_valid = res_fire | (r_out_valid & ~i_out_ready);
    end

    // Control and store registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RESET;
            r_pos        <= '0;
            r_hdr_xor    <= '0;
            r_pay_xor    <= '0;
            r_start_ok   <= 1'b0;
            r_type       <= '0;
            r_hdr_chk    <= '0;
            r_breath     <= '0;
            r_heart      <= '0;
            r_distance   <= '0;
            r_present    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start_byte <= i_cfg_wdata;
            end
            r_pos       <= n_pos;
            r_hdr_xor   <= n_hdr_xor;
            r_pay_xor   <= n_pay_xor;
            r_start_ok  <= n_start_ok;
            r_type      <= n_type;
            r_hdr_chk   <= n_hdr_chk;
            r_breath    <= n_breath;
            r_heart     <= n_heart;
            r_distance  <= n_distance;
            r_present   <= n_present;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload word buffer, byte lane writes
    always_ff @(posedge i_clk) begin
        if (word_we) begin
            r_words[word_sel][word_lane*BYTE_W +: BYTE_W] <= i_byte_value;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (res_fire) begin
            r_out_status <= res_status;
            r_out_kind   <= cur_kind;
            r_out_type   <= r_type;
        end
    end

    // Stores only change on a beat that also loads a result, and no such beat is
    // accepted while a result is held, so they read out directly.
    assign o_out_valid           = r_out_valid;
    assign o_frame_status        = r_out_status;
    assign o_frame_kind          = r_out_kind;
    assign o_raw_type_code       = r_out_type;
    assign o_breath_value_bits   = r_breath;
    assign o_heart_value_bits    = r_heart;
    assign o_distance_value_bits = r_distance;
    assign o_target_present      = r_present;

endmodule

// ===== hw/rtl/rvfp_checker.sv =====
// Port-level checks for the radar vital frame parser, bound to the top level.
// Depends on rvfp_pkg and radar_vital_frame_parser.
module rvfp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [rvfp_pkg::STATUS_W-1:0]   o_frame_status,
    input  logic [rvfp_pkg::KIND_W-1:0]     o_frame_kind,
    input  logic [rvfp_pkg::TYPE_W-1:0]     o_raw_type_code,
    input  logic [rvfp_pkg::WORD_W-1:0]     o_breath_value_bits,
    input  logic [rvfp_pkg::WORD_W-1:0]     o_heart_value_bits,
    input  logic [rvfp_pkg::WORD_W-1:0]     o_distance_value_bits,
    input  logic                            o_target_present
);
    import rvfp_pkg::*;

    // A held result keeps its beat until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_frame_status) && $stable(o_frame_kind)
             && $stable(o_raw_type_code)))
        else $error("result changed while stalled");

    // An empty result slot never stalls the byte stream
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // A fresh result always follows an accepted byte beat
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && $past(i_rst_n) && !($past(o_out_valid) && !$past(i_out_ready)))
            |-> $past(i_in_valid && o_in_ready))
        else $error("result without an input beat");

    // Stores move only together with a new result
    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ((o_breath_value_bits != $past(o_breath_value_bits))
            || (o_heart_value_bits != $past(o_heart_value_bits))
            || (o_distance_value_bits != $past(o_distance_value_bits))
            || (o_target_present != $past(o_target_present))))
            |-> (o_out_valid && $past(i_in_valid && o_in_ready)))
        else $error("store changed without a result");

    // An unknown type never reports a data error
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_kind == KIND_UNKNOWN) |-> (o_frame_status != ST_DATA_ERR))
        else $error("data error reported on unknown type");

endmodule

bind radar_vital_frame_parser rvfp_checker u_rvfp_checker (.*);

// ===== dv/tb_radar_vital_frame_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for radar_vital_frame_parser: a directed frame table, then random
// frame streams under several idle and back-pressure mixes, all scored against a byte predictor.
// Depends on rvfp_pkg and the radar_vital_frame_parser RTL.
module tb_radar_vital_frame_parser;
    import rvfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PLAN_ROWS      = 18;
    localparam int PHASE_BYTES    = 50;

    // One frame's worth of expected output
    typedef struct {
        t_status             status;
        t_kind               kind;
        logic [TYPE_W-1:0]   code;
        logic [WORD_W-1:0]   breath;
        logic [WORD_W-1:0]   heart;
        logic [WORD_W-1:0]   distance;
        logic                present;
    } t_frame_result;

    // One row of the directed frame plan
    typedef struct packed {
        logic [BYTE_W-1:0]   lead;
        logic [TYPE_W-1:0]   code;
        logic [WORD_W-1:0]   w0;
        logic [WORD_W-1:0]   w1;
        logic [WORD_W-1:0]   w2;
        logic                hdr_bad;
        logic                data_bad;
        logic                typed;
        t_status             want_status;
        t_kind               want_kind;
    } t_frame_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [BYTE_W-1:0]     i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [BYTE_W-1:0]     i_byte_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [STATUS_W-1:0]   o_frame_status;
    logic [KIND_W-1:0]     o_frame_kind;
    logic [TYPE_W-1:0]     o_raw_type_code;
    logic [WORD_W-1:0]     o_breath_value_bits;
    logic [WORD_W-1:0]     o_heart_value_bits;
    logic [WORD_W-1:0]     o_distance_value_bits;
    logic                  o_target_present;

    radar_vital_frame_parser dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_byte_value          (i_byte_value),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_frame_status        (o_frame_status),
        .o_frame_kind          (o_frame_kind),
        .o_raw_type_code       (o_raw_type_code),
        .o_breath_value_bits   (o_breath_value_bits),
        .o_heart_value_bits    (o_heart_value_bits),
        .o_distance_value_bits (o_distance_value_bits),
        .o_target_present      (o_target_present)
    );

    always #6 i_clk = ~i_clk;

    // Predictor copy of the parser state, at reset values
    logic [BYTE_W-1:0]  start_cfg = START_BYTE_RESET;
    logic [POS_W-1:0]   pos_q = '0;
    logic [BYTE_W-1:0]  hdr_acc = '0;
    logic [BYTE_W-1:0]  body_acc = '0;
    logic               lead_ok = 1'b0;
    logic [TYPE_W-1:0]  code_q = '0;
    logic [BYTE_W-1:0]  hdr_chk = '0;
    logic [WORD_W-1:0]  words [3] = '{'0, '0, '0};
    logic [WORD_W-1:0]  breath_q = '0;
    logic [WORD_W-1:0]  heart_q = '0;
    logic [WORD_W-1:0]  dist_q = '0;
    logic               present_q = 1'b0;

    t_frame_result frames_due [$];

    int mismatches = 0;
    int results_seen = 0;
    int results_queued = 0;
    int bytes_sent = 0;
    int phase_bytes = 0;
    int stall_cycles = 0;
    int send_pct_now = 0;
    int recv_pct_now = 0;

    function automatic t_kind kind_for(input logic [TYPE_W-1:0] code);
        case (code)
            TYPE_ALL:      return KIND_ALL;
            TYPE_BREATH:   return KIND_BREATH;
            TYPE_HEART:    return KIND_HEART;
            TYPE_DISTANCE: return KIND_DISTANCE;
            default:       return KIND_UNKNOWN;
        endcase
    endfunction

    function automatic int body_len(input logic [TYPE_W-1:0] code);
        case (code)
            TYPE_ALL:      return FULL_PAYLOAD_BYTES;
            TYPE_DISTANCE: return DIST_PAYLOAD_BYTES;
            default:       return SINGLE_PAYLOAD_BYTES;
        endcase
    endfunction

    // Advance the predicted parser by one accepted byte; queue a result at frame end
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        t_frame_result r;
        t_kind         k;
        logic [POS_W-1:0] p;
        logic          hdr_good;
        logic          data_good;
        if (pos_q < HEADER_BYTES) begin
            if (pos_q == 0) lead_ok = (b == start_cfg);
            if (pos_q < HDR_SUM_BYTES) hdr_acc = hdr_acc ^ b;
            else hdr_chk = b;
            if (pos_q == TYPE_HI_POS) code_q[15:8] = b;
            if (pos_q == TYPE_LO_POS) code_q[7:0] = b;
            pos_q = pos_q + 1'b1;
        end else begin
            k = kind_for(code_q);
            p = pos_q - POS_W'(HEADER_BYTES);
            if (p < body_len(code_q)) begin
                body_acc = body_acc ^ b;
                words[p[3:2]][{p[1:0], 3'b000} +: 8] = b;
                pos_q = pos_q + 1'b1;
            end else begin
                // checksum byte closes the frame
                hdr_good = (~hdr_acc == hdr_chk);
                data_good = (~body_acc == b);
                pos_q = '0;
                hdr_acc = '0;
                body_acc = '0;
                if (lead_ok) begin
                    r.status = ST_OK;
                    if (!hdr_good) begin
                        r.status = ST_HDR_ERR;
                    end else if (k != KIND_UNKNOWN) begin
                        if (!data_good) begin
                            r.status = ST_DATA_ERR;
                        end else begin
                            case (k)
                                KIND_ALL: begin
                                    breath_q = words[0];
                                    heart_q = words[1];
                                end
                                KIND_BREATH: breath_q = words[0];
                                KIND_HEART:  heart_q = words[0];
                                default: begin
                                    present_q = (words[0] == 32'd1);
                                    dist_q = words[1];
                                end
                            endcase
                        end
                    end
                    r.kind = k;
                    r.code = code_q;
                    r.breath = breath_q;
                    r.heart = heart_q;
                    r.distance = dist_q;
                    r.present = present_q;
                    frames_due.push_back(r);
                    results_queued++;
                end
            end
        end
    endtask

    // Directed frames; status and kind are typed in where they are obvious
    function automatic t_frame_row plan_row(input int idx);
        case (idx)
            // header fault right after reset: stores still zero
            0:  return '{8'h01, TYPE_HEART, 32'h42A00000, 32'h0, 32'h0,
                         1'b1, 1'b0, 1'b1, ST_HDR_ERR, KIND_HEART};
            1:  return '{8'h01, TYPE_BREATH, 32'hFFFFFFFF, 32'h0, 32'h0,
                         1'b0, 1'b0, 1'b1, ST_OK, KIND_BREATH};
            2:  return '{8'h01, TYPE_HEART, 32'h80000000, 32'h0, 32'h0,
                         1'b0, 1'b0, 1'b1, ST_OK, KIND_HEART};
            3:  return '{8'h01, TYPE_ALL, 32'h3F800000, 32'h42F00000, 32'hFFFFFFFF,
                         1'b0, 1'b0, 1'b1, ST_OK, KIND_ALL};
            // presence flag word exactly one
            4:  return '{8'h01, TYPE_DISTANCE, 32'h00000001, 32'h43480000, 32'h0,
                         1'b0, 1'b0, 1'b1, ST_OK, KIND_DISTANCE};
            5:  return '{8'h01, TYPE_DISTANCE, 32'h00000100, 32'h0, 32'h0,
                         1'b0, 1'b0, 1'b1, ST_OK, KIND_DISTANCE};
            // flag byte in the wrong lane: not present
            6:  return '{8'h01, TYPE_DISTANCE, 32'h01000000, 32'hFFFFFFFF, 32'h0,
                         1'b0, 1'b0, 1'b0, ST_OK, KIND_ALL};
            7:  return '{8'h01, 16'h0000, 32'h12345678, 32'h0, 32'h0,
                         1'b0, 1'b0, 1'b1, ST_OK, KIND_UNKNOWN};
            // unknown type: data checksum ignored
            8:  return '{8'h01, 16'hFFFF, 32'hA5A5A5A5, 32'h0, 32'h0,
                         1'b0, 1'b1, 1'b1, ST_OK, KIND_UNKNOWN};
            9:  return '{8'h01, 16'h0A12, 32'h5A5A5A5A, 32'h0, 32'h0,
                         1'b0, 1'b1, 1'b1, ST_OK, KIND_UNKNOWN};
            10: return '{8'h01, 16'h0A17, 32'hDEADBEEF, 32'h0, 32'h0,
                         1'b0, 1'b0, 1'b1, ST_OK, KIND_UNKNOWN};
            // header fault on a full frame still counts out twelve payload bytes
            11: return '{8'h01, TYPE_ALL, 32'h11111111, 32'h22222222, 32'h33333333,
                         1'b1, 1'b0, 1'b1, ST_HDR_ERR, KIND_ALL};
            12: return '{8'h01, TYPE_DISTANCE, 32'h00000001, 32'h44444444, 32'h0,
                         1'b0, 1'b1, 1'b1, ST_DATA_ERR, KIND_DISTANCE};
            13: return '{8'h01, TYPE_BREATH, 32'h55555555, 32'h0, 32'h0,
                         1'b0, 1'b1, 1'b1, ST_DATA_ERR, KIND_BREATH};
            // wrong start byte: counted out silently
            14: return '{8'h00, TYPE_BREATH, 32'h66666666, 32'h0, 32'h0,
                         1'b0, 1'b0, 1'b0, ST_OK, KIND_ALL};
            15: return '{8'hFF, TYPE_ALL, 32'h77777777, 32'h88888888, 32'h0,
                         1'b1, 1'b0, 1'b0, ST_OK, KIND_ALL};
            16: return '{8'h01, TYPE_ALL, 32'h0, 32'h0, 32'h0,
                         1'b0, 1'b0, 1'b0, ST_OK, KIND_ALL};
            default: return '{8'h01, 16'h1234, 32'h99999999, 32'h0, 32'h0,
                         1'b1, 1'b1, 1'b1, ST_HDR_ERR, KIND_UNKNOWN};
        endcase
    endfunction

    // Drive one byte beat and wait for it to be taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_pct_now) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_value <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_byte(b);
        bytes_sent++;
        phase_bytes++;
    endtask

    // Build a frame with proper or damaged checksums and send it
    task automatic send_frame(input logic [BYTE_W-1:0] lead, input logic [TYPE_W-1:0] code,
                              input logic [WORD_W-1:0] w0, w1, w2,
                              input logic hdr_bad, data_bad);
        logic [BYTE_W-1:0] beats [$];
        logic [WORD_W-1:0] wd [3];
        logic [BYTE_W-1:0] acc;
        int                n;
        wd[0] = w0;
        wd[1] = w1;
        wd[2] = w2;
        beats.push_back(lead);
        repeat (4) beats.push_back(8'($urandom));
        beats.push_back(code[15:8]);
        beats.push_back(code[7:0]);
        acc = '0;
        foreach (beats[i]) acc = acc ^ beats[i];
        acc = ~acc;
        if (hdr_bad) acc = acc ^ (8'd1 << $urandom_range(0, 7));
        beats.push_back(acc);
        n = body_len(code);
        acc = '0;
        for (int i = 0; i < n; i++) begin
            beats.push_back(wd[i / 4][8 * (i % 4) +: 8]);
            acc = acc ^ wd[i / 4][8 * (i % 4) +: 8];
        end
        acc = ~acc;
        if (data_bad) acc = acc ^ 8'($urandom_range(1, 255));
        beats.push_back(acc);
        foreach (beats[i]) send_byte(beats[i]);
    endtask

    // Mostly well-formed frames with random content, some faults and raw noise
    task automatic send_random_frame();
        logic [TYPE_W-1:0] code;
        logic [WORD_W-1:0] w0;
        logic [BYTE_W-1:0] lead;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // noise, then random bytes until the parser is back at a frame start
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            while (pos_q != 0) send_byte(8'($urandom));
        end else begin
            case ($urandom_range(0, 9))
                0, 1:    code = TYPE_ALL;
                2, 3:    code = TYPE_BREATH;
                4, 5:    code = TYPE_HEART;
                6, 7:    code = TYPE_DISTANCE;
                8:       code = TYPE_ALL ^ (16'd1 << $urandom_range(0, 15));
                default: code = 16'($urandom);
            endcase
            w0 = $urandom;
            if (code == TYPE_DISTANCE) begin
                case ($urandom_range(0, 3))
                    0, 1:    w0 = 32'd1;
                    2:       w0 = 32'd1 << $urandom_range(1, 31);
                    default: w0 = $urandom;
                endcase
            end
            lead = (pick < 16) ? (start_cfg ^ 8'($urandom_range(1, 255))) : start_cfg;
            send_frame(lead, code, w0, $urandom, $urandom,
                       $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 8);
        end
    endtask

    // Wait until all results are out and the block has gone quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_byte(input logic [BYTE_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        start_cfg = value;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result scoreboard, receiver back-pressure and watchdog
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        i_out_ready <= ($urandom_range(0, 99) >= recv_pct_now);
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: result with nothing expected, status %0d kind %0d type %h",
                             $time, o_frame_status, o_frame_kind, o_raw_type_code);
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("frame_status", 32'(want.status), 32'(o_frame_status));
                    check_field("frame_kind", 32'(want.kind), 32'(o_frame_kind));
                    check_field("raw_type_code", 32'(want.code), 32'(o_raw_type_code));
                    check_field("breath_value_bits", want.breath, o_breath_value_bits);
                    check_field("heart_value_bits", want.heart, o_heart_value_bits);
                    check_field("distance_value_bits", want.distance, o_distance_value_bits);
                    check_field("target_present", 32'(want.present), 32'(o_target_present));
                    results_seen++;
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, stall_cycles, frames_due.size());
                $display("simulation failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        t_frame_row        row;
        t_frame_result     held;
        int                due_before;
        logic [BYTE_W-1:0] setting;
        logic              quiet;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at the reset start byte, no idling
        for (int r = 0; r < PLAN_ROWS; r++) begin
            row = plan_row(r);
            due_before = results_queued;
            send_frame(row.lead, row.code, row.w0, row.w1, row.w2, row.hdr_bad, row.data_bad);
            // the frame's result was queued at its last beat and is still waiting
            if (row.typed && results_queued > due_before) begin
                held = frames_due.pop_back();
                held.status = row.want_status;
                held.kind = row.want_kind;
                frames_due.push_back(held);
            end
        end

        // random phases: start byte setting and idle mix change per phase
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0:       setting = 8'h00;
                1:       setting = 8'hFF;
                2:       setting = 8'($urandom_range(2, 254));
                default: setting = START_BYTE_RESET;
            endcase
            write_start_byte(setting);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                quiet = ($urandom_range(0, 7) == 0);
                case (ph)
                    0: begin
                        send_pct_now = 0;
                        recv_pct_now = 0;
                    end
                    1: begin
                        send_pct_now = quiet ? 0 : 69;
                        recv_pct_now = 0;
                    end
                    2: begin
                        send_pct_now = 0;
                        recv_pct_now = quiet ? 0 : 69;
                    end
                    default: begin
                        send_pct_now = quiet ? 0 : 38;
                        recv_pct_now = quiet ? 0 : 38;
                    end
                endcase
                send_random_frame();
            end
        end
        settle();

        $display("run covered %0d stream bytes and %0d checked frame results", bytes_sent,
                 results_seen);
        $display("start bytes 0x01, 0x00, 0xFF and a random one; all frame kinds and faults");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== radar_vital_frame_parser.f =====
hw/rtl/rvfp_pkg.sv
hw/rtl/radar_vital_frame_parser.sv
hw/rtl/rvfp_checker.sv
dv/tb_radar_vital_frame_parser.sv
